// ===== rtl/srs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

  typedef enum logic {
    ActAdd   = 1'b0,
    ActClear = 1'b1
  } action_e;

  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = 32;

  localparam logic [CfgAddrBits-3:0] RegEchoTimeout = '0;

  localparam int EchoTimeoutReset = 3000;

endpackage

`default_nettype wire

// ===== rtl/srs_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface srs_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/srs_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface srs_out_if #(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 24
);
  localparam int SumBits = COUNT_BITS + SAMPLE_BITS;
  localparam int SqBits  = COUNT_BITS + 2 * SAMPLE_BITS;

  logic                   valid;
  logic                   ready;
  logic [COUNT_BITS-1:0]  sample_count;
  logic [SAMPLE_BITS-1:0] min_value;
  logic [SAMPLE_BITS-1:0] max_value;
  logic [SumBits-1:0]     value_sum;
  logic [SqBits-1:0]      square_sum;
  logic [SumBits-1:0]     motion_total;
  logic [COUNT_BITS-1:0]  motion_count;

  modport source (
    output valid, output sample_count, output min_value, output max_value,
    output value_sum, output square_sum, output motion_total, output motion_count,
    input ready
  );
  modport sink (
    input valid, input sample_count, input min_value, input max_value,
    input value_sum, input square_sum, input motion_total, input motion_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/srs_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srs_cfg_regs
  import srs_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CfgAddrBits-1:0] paddr,
  input  wire logic [CfgDataBits-1:0] pwdata,
  output logic      [CfgDataBits-1:0] prdata,
  output logic                        pready,
  output logic      [SAMPLE_BITS-1:0] echo_timeout_o
);

  localparam logic [SAMPLE_BITS-1:0] TimeoutReset = SAMPLE_BITS'(EchoTimeoutReset);

  logic                   timeout_sel;
  logic                   timeout_we;
  logic [SAMPLE_BITS-1:0] timeout_d;
  logic [SAMPLE_BITS-1:0] timeout_q;

  assign pready      = 1'b1;
  assign timeout_sel = (paddr[CfgAddrBits-1:2] == RegEchoTimeout);
  assign timeout_we  = psel && penable && pwrite && timeout_sel;
  assign timeout_d   = timeout_we ? pwdata[SAMPLE_BITS-1:0] : timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (timeout_sel) begin
      prdata = CfgDataBits'(timeout_q);
    end
  end

  assign echo_timeout_o = timeout_q;

endmodule

`default_nettype wire

// ===== rtl/srs_stats_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srs_stats_core
  import srs_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 24
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      update_i,
  input  wire action_e                   action_i,
  input  wire logic [SAMPLE_BITS-1:0]    sample_i,
  input  wire logic [SAMPLE_BITS-1:0]    echo_timeout_i,
  output logic [COUNT_BITS-1:0]          sample_count_o,
  output logic [SAMPLE_BITS-1:0]         min_value_o,
  output logic [SAMPLE_BITS-1:0]         max_value_o,
  output logic [COUNT_BITS+SAMPLE_BITS-1:0]   value_sum_o,
  output logic [COUNT_BITS+2*SAMPLE_BITS-1:0] square_sum_o,
  output logic [COUNT_BITS+SAMPLE_BITS-1:0]   motion_total_o,
  output logic [COUNT_BITS-1:0]          motion_count_o
);

  localparam int SumBits = COUNT_BITS + SAMPLE_BITS;
  localparam int SqBits  = COUNT_BITS + 2 * SAMPLE_BITS;

  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d;
  logic [SAMPLE_BITS-1:0] max_q, max_d;
  logic [SumBits-1:0]     sum_q, sum_d;
  logic [SqBits-1:0]      sumsq_q, sumsq_d;
  logic [SumBits-1:0]     motion_q, motion_d;
  logic [COUNT_BITS-1:0]  delta_cnt_q, delta_cnt_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic                   have_prev_q, have_prev_d;

  logic [SAMPLE_BITS-1:0]   s_eff;
  logic [2*SAMPLE_BITS-1:0] s_sq;
  logic [SAMPLE_BITS-1:0]   s_diff;
  logic [COUNT_BITS:0]      count_inc;
  logic [COUNT_BITS:0]      delta_inc;
  logic [SumBits:0]         sum_inc;
  logic [SqBits:0]          sumsq_inc;
  logic [SumBits:0]         motion_inc;

  assign s_eff     = (sample_i == '0) ? echo_timeout_i : sample_i;
  assign s_sq      = (2*SAMPLE_BITS)'(s_eff) * (2*SAMPLE_BITS)'(s_eff);
  assign s_diff    = (s_eff > prev_q) ? (s_eff - prev_q) : (prev_q - s_eff);
  assign count_inc = {1'b0, count_q} + (COUNT_BITS+1)'(1);
  assign delta_inc = {1'b0, delta_cnt_q} + (COUNT_BITS+1)'(1);
  assign sum_inc   = {1'b0, sum_q} + (SumBits+1)'(s_eff);
  assign sumsq_inc = {1'b0, sumsq_q} + (SqBits+1)'(s_sq);
  assign motion_inc = {1'b0, motion_q} + (SumBits+1)'(s_diff);

  always_comb begin
    count_d     = count_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    sumsq_d     = sumsq_q;
    motion_d    = motion_q;
    delta_cnt_d = delta_cnt_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    if (update_i) begin
      case (action_i)
        ActClear: begin
          count_d     = '0;
          min_d       = '0;
          max_d       = '0;
          sum_d       = '0;
          sumsq_d     = '0;
          motion_d    = '0;
          delta_cnt_d = '0;
          prev_d      = '0;
          have_prev_d = 1'b0;
        end
        ActAdd: begin
          if (count_q == '0) begin
            min_d = s_eff;
            max_d = s_eff;
          end else begin
            if (s_eff < min_q) min_d = s_eff;
            if (s_eff > max_q) max_d = s_eff;
          end
          count_d = count_inc[COUNT_BITS] ? '1 : count_inc[COUNT_BITS-1:0];
          sum_d   = sum_inc[SumBits] ? '1 : sum_inc[SumBits-1:0];
          sumsq_d = sumsq_inc[SqBits] ? '1 : sumsq_inc[SqBits-1:0];
          if (have_prev_q) begin
            motion_d    = motion_inc[SumBits] ? '1 : motion_inc[SumBits-1:0];
            delta_cnt_d = delta_inc[COUNT_BITS] ? '1 : delta_inc[COUNT_BITS-1:0];
          end
          have_prev_d = 1'b1;
          prev_d      = s_eff;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      motion_q    <= '0;
      delta_cnt_q <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      sumsq_q     <= sumsq_d;
      motion_q    <= motion_d;
      delta_cnt_q <= delta_cnt_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
    end
  end

  // statistics registers double as the result register
  assign sample_count_o = count_q;
  assign min_value_o    = min_q;
  assign max_value_o    = max_q;
  assign value_sum_o    = sum_q;
  assign square_sum_o   = sumsq_q;
  assign motion_total_o = motion_q;
  assign motion_count_o = delta_cnt_q;

endmodule

`default_nettype wire

// ===== rtl/sensor_running_statistics_top.sv =====
// channel   dir   transfer when        payload
// in_i      in    valid && ready       action, sample
// out_o     out   valid && ready       sample_count .. motion_count
// apb       in    psel && penable      echo_timeout at byte address 0
//
// an item is captured in the input register, then the statistics update
// loads the result; one item per cycle sustained while out_o.ready is high
// reset clears all statistics and sets echo_timeout to 3000
// a stalled result holds the statistics; one more item waits in the input
// register before in_i.ready drops
`timescale 1ns / 1ps
`default_nettype none

module sensor_running_statistics_top
  import srs_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  srs_in_if.sink                      in_i,
  srs_out_if.source                   out_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CfgAddrBits-1:0] paddr,
  input  wire logic [CfgDataBits-1:0] pwdata,
  output logic      [CfgDataBits-1:0] prdata,
  output logic                        pready
);

  logic [SAMPLE_BITS-1:0] echo_timeout;

  logic                   in_valid_q, in_valid_d;
  action_e                in_action_q;
  logic [SAMPLE_BITS-1:0] in_sample_q;
  logic                   out_valid_q, out_valid_d;
  logic                   in_xfer;
  logic                   advance;

  srs_cfg_regs #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .echo_timeout_o (echo_timeout)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_action_q <= action_e'(in_i.action);
      in_sample_q <= in_i.sample;
    end
  end

  srs_stats_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .update_i       (advance),
    .action_i       (in_action_q),
    .sample_i       (in_sample_q),
    .echo_timeout_i (echo_timeout),
    .sample_count_o (out_o.sample_count),
    .min_value_o    (out_o.min_value),
    .max_value_o    (out_o.max_value),
    .value_sum_o    (out_o.value_sum),
    .square_sum_o   (out_o.square_sum),
    .motion_total_o (out_o.motion_total),
    .motion_count_o (out_o.motion_count)
  );

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire
